FILE: rtl/lcd4_pkg.sv
`default_nettype none

package lcd4_pkg;

	localparam int unsigned ValueW   = 14;
	localparam int unsigned WordW    = 32;
	localparam int unsigned Digits   = 4;
	localparam int unsigned Segments = 7;
	localparam int unsigned PinW     = 5;

	localparam int unsigned BackplaneBit = 25;
	localparam logic [ValueW-1:0] MaxShown = ValueW'(9999);

	typedef logic [Segments-1:0] glyph_t;
	typedef logic [PinW-1:0]     pin_t;

	// Glyphs, bit order GFEDCBA
	localparam glyph_t GLYPH_0     = 7'b0111111;
	localparam glyph_t GLYPH_1     = 7'b0000110;
	localparam glyph_t GLYPH_2     = 7'b1011011;
	localparam glyph_t GLYPH_3     = 7'b1001111;
	localparam glyph_t GLYPH_4     = 7'b1100110;
	localparam glyph_t GLYPH_5     = 7'b1101101;
	localparam glyph_t GLYPH_6     = 7'b1111101;
	localparam glyph_t GLYPH_7     = 7'b0000111;
	localparam glyph_t GLYPH_8     = 7'b1111111;
	localparam glyph_t GLYPH_9     = 7'b1101111;
	localparam glyph_t GLYPH_BLANK = 7'b0000000;

	// Pin of segment A..G for each digit, units digit first
	localparam pin_t SEG_PIN [Digits][Segments] = '{
		'{5'd15, 5'd8,  5'd16, 5'd21, 5'd22, 5'd14, 5'd13},
		'{5'd10, 5'd9,  5'd20, 5'd19, 5'd18, 5'd11, 5'd12},
		'{5'd7,  5'd0,  5'd24, 5'd30, 5'd31, 5'd6,  5'd5},
		'{5'd2,  5'd1,  5'd28, 5'd27, 5'd26, 5'd3,  5'd4}
	};

	// Seven-segment font; codes above nine show blank
	function automatic glyph_t font(input logic [3:0] digit);
		glyph_t g;
		unique case (digit)
			4'd0: g = GLYPH_0;
			4'd1: g = GLYPH_1;
			4'd2: g = GLYPH_2;
			4'd3: g = GLYPH_3;
			4'd4: g = GLYPH_4;
			4'd5: g = GLYPH_5;
			4'd6: g = GLYPH_6;
			4'd7: g = GLYPH_7;
			4'd8: g = GLYPH_8;
			4'd9: g = GLYPH_9;
			default: g = GLYPH_BLANK;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/static_lcd_four_digit_driver.sv
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata[13:0] display_value
// m        out  m_tvalid/m_tready  m_tdata[31:0] frame_word, m_tuser[0] frame_phase
//
// One tick per cycle sustained while m_tready stays high; the result reaches m_tdata
// through the input register, then the result register.
// Digit split uses constant reciprocal multiplies computed in parallel.
// arst_n clears the valid bits and the drive phase (next tick uses phase 0).
// A stalled output register backs up into the input register before s_tready drops.
`default_nettype none

module static_lcd_four_digit_driver
	import lcd4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [13:0] display_value, [15:14] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] frame_word
	output logic [0:0]       m_tuser    // [0] frame_phase
);

	logic              phase_q;
	logic              valid_s1;
	logic [ValueW-1:0] value_s1;
	logic              phase_s1;
	logic              valid_s2;
	logic [WordW-1:0]  word_s2;
	logic              phase_s2;

	logic              adv_s1;
	logic              in_xfer;

	// Stage 1 moves on when the result register is empty or being drained
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign in_xfer  = s_tvalid && s_tready;

	// Input register and drive phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (in_xfer) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_s1 <= s_tdata[ValueW-1:0];
			phase_s1 <= phase_q;
		end
	end

	// Saturate and split into decimal digits
	logic [ValueW-1:0] sat;
	logic [27:0]       prod_th;
	logic [26:0]       prod_h;
	logic [26:0]       prod_t;
	logic [3:0]        q1000;
	logic [6:0]        q100;
	logic [9:0]        q10;
	logic [3:0]        dig [Digits];
	logic [Digits-1:0] show;

	always_comb begin
		sat     = (value_s1 > MaxShown) ? MaxShown : value_s1;
		prod_th = 28'(sat) * 28'd8389;
		prod_h  = 27'(sat) * 27'd5243;
		prod_t  = 27'(sat) * 27'd6554;
		q1000   = prod_th[26:23];
		q100    = prod_h[25:19];
		q10     = prod_t[25:16];
		dig[0]  = 4'(sat - ValueW'(q10) * ValueW'(10));
		dig[1]  = 4'(q10 - 10'(q100) * 10'd10);
		dig[2]  = 4'(q100 - 7'(q1000) * 7'd10);
		dig[3]  = q1000;
		show[0] = 1'b1;
		show[1] = sat > ValueW'(9);
		show[2] = sat > ValueW'(99);
		show[3] = sat > ValueW'(999);
	end

	// Font lookup, scatter onto the pin map, then phase inversion and backplane bit
	logic [WordW-1:0] segs;
	logic [WordW-1:0] word_d;
	glyph_t           g [Digits];

	always_comb begin
		segs = '0;
		for (int d = 0; d < Digits; d++) begin
			g[d] = show[d] ? font(dig[d]) : GLYPH_BLANK;
			for (int s = 0; s < Segments; s++) begin
				segs[SEG_PIN[d][s]] = g[d][s];
			end
		end
		if (!phase_s1) begin
			word_d = segs;
			word_d[BackplaneBit] = 1'b0;
		end else begin
			word_d = ~segs;
			word_d[BackplaneBit] = 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			word_s2  <= word_d;
			phase_s2 <= phase_s1;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = word_s2;
	assign m_tuser[0] = phase_s2;

endmodule

`default_nettype wire
